/* rtl/rcc_pkg.sv */
package rcc_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int LABEL_BITS_DEF = 16;

  localparam int OUT_BITS      = 16;
  localparam int Y_BITS        = 8;
  localparam int CFG_IDX_BITS  = 2;
  localparam int CFG_DATA_BITS = 9;

  localparam logic [CFG_IDX_BITS-1:0]  REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0]  REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_DATA_BITS-1:0] DIM_RESET        = 9'd256;

  // broadcast to every label cell
  typedef struct packed {
    logic shift;
    logic merge;
  } cell_ctrl_t;

endpackage

/* rtl/rcc_pix_if.sv */
interface rcc_pix_if;
  logic valid;
  logic ready;
  logic pixel;

  modport source (output valid, output pixel, input ready);
  modport sink   (input valid, input pixel, output ready);
endinterface

/* rtl/rcc_res_if.sv */
interface rcc_res_if;
  logic                          valid;
  logic                          ready;
  logic [rcc_pkg::OUT_BITS-1:0]  pixel_label;
  logic [rcc_pkg::OUT_BITS-1:0]  part_count;
  logic                          frame_done;

  modport source (output valid, output pixel_label, output part_count, output frame_done,
                  input ready);
  modport sink   (input valid, input pixel_label, input part_count, input frame_done,
                  output ready);
endinterface

/* rtl/rcc_cfg_if.sv */
interface rcc_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [rcc_pkg::CFG_IDX_BITS-1:0]  index;
  logic [rcc_pkg::CFG_DATA_BITS-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/rcc_cell.sv */
module rcc_cell #(
  parameter int LABEL_BITS = rcc_pkg::LABEL_BITS_DEF,
  parameter int XW         = 8,
  parameter int IDX        = 0
) (
  input  logic                  clk,
  input  rcc_pkg::cell_ctrl_t   ctrl,
  input  logic [XW-1:0]         start,
  input  logic [LABEL_BITS-1:0] prev_lab,
  input  logic [LABEL_BITS-1:0] from_lab,
  input  logic [LABEL_BITS-1:0] to_lab,
  input  logic [LABEL_BITS-1:0] new_lab,
  output logic [LABEL_BITS-1:0] lab_q
);

  logic [LABEL_BITS-1:0] lab_r;
  logic [LABEL_BITS-1:0] lab_nxt;

  // head of the active window takes the fresh label, the rest shift with rewrite
  always_comb begin
    if (start == XW'(IDX)) begin
      lab_nxt = new_lab;
    end else if (ctrl.merge && (prev_lab == from_lab)) begin
      lab_nxt = to_lab;
    end else begin
      lab_nxt = prev_lab;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      lab_r <= lab_nxt;
    end
  end

  assign lab_q = lab_r;

endmodule

/* rtl/rcc_row.sv */
module rcc_row #(
  parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_BITS = rcc_pkg::LABEL_BITS_DEF,
  localparam int XW        = $clog2(MAX_WIDTH)
) (
  input  logic                  clk,
  input  rcc_pkg::cell_ctrl_t   ctrl,
  input  logic [XW-1:0]         start,
  input  logic [LABEL_BITS-1:0] from_lab,
  input  logic [LABEL_BITS-1:0] to_lab,
  input  logic [LABEL_BITS-1:0] new_lab,
  output logic [LABEL_BITS-1:0] up_lab
);

  logic [LABEL_BITS-1:0] lab [MAX_WIDTH];

  for (genvar i = 0; i < MAX_WIDTH; i++) begin : g_cell
    logic [LABEL_BITS-1:0] prev;
    if (i == 0) begin : g_first
      assign prev = '0;
    end else begin : g_link
      assign prev = lab[i-1];
    end

    rcc_cell #(
      .LABEL_BITS (LABEL_BITS),
      .XW         (XW),
      .IDX        (i)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .start    (start),
      .prev_lab (prev),
      .from_lab (from_lab),
      .to_lab   (to_lab),
      .new_lab  (new_lab),
      .lab_q    (lab[i])
    );
  end

  // last cell holds the word written one row ago
  assign up_lab = lab[MAX_WIDTH-1];

endmodule

/* rtl/raster_component_counter.sv */
// channel  | dir | word                                     | handshake
// in_pix   | in  | pixel                                    | valid/ready
// out_res  | out | pixel_label, part_count, frame_done      | valid/ready
// cfg_wr   | in  | index, data (image_width, image_height)  | valid/ready, ready tied high
//
// One pixel per clock while the output is not stalled; its result is registered in the output register.
// Labels sit in a row of cells that shifts once per pixel; the active window is the
// last image_width cells, so the label above is always the final cell. On a merge every
// cell rewrites in the same cycle, so the rate does not depend on the image.
// rst_n (synchronous) restarts the frame and sets both sizes to 256; a size register
// write also restarts the frame. A stalled output holds and stalls the input.
module raster_component_counter #(
  parameter int MAX_WIDTH  = rcc_pkg::MAX_WIDTH_DEF,
  parameter int LABEL_BITS = rcc_pkg::LABEL_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  rcc_pix_if.sink   in_pix,
  rcc_res_if.source out_res,
  rcc_cfg_if.sink   cfg_wr
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int EW = $clog2(MAX_WIDTH + 1) + rcc_pkg::CFG_DATA_BITS;
  localparam int CW = (LABEL_BITS > rcc_pkg::OUT_BITS) ? LABEL_BITS : rcc_pkg::OUT_BITS;
  localparam int PW = LABEL_BITS + rcc_pkg::OUT_BITS;
  localparam int YW = rcc_pkg::Y_BITS;
  localparam logic [LABEL_BITS-1:0] LabelMax = '1;

  logic [rcc_pkg::CFG_DATA_BITS-1:0] width_r, height_r;
  logic [XW-1:0]         x_r;
  logic [YW-1:0]         y_r;
  logic [LABEL_BITS-1:0] next_r, merges_r, left_r;
  logic                  out_valid_r;
  logic [rcc_pkg::OUT_BITS-1:0] label_r, count_r;
  logic                  done_r;

  logic                  in_acc, cfg_acc;
  logic [EW-1:0]         w_ext, w_eff;
  logic [XW-1:0]         w_m1, start;
  logic [rcc_pkg::CFG_DATA_BITS-1:0] h_dec;
  logic [YW-1:0]         h_m1;
  logic [LABEL_BITS-1:0] up_lab, left_c, up_c, lab_c;
  logic                  merge_c, fresh_c, done_c;
  logic [LABEL_BITS-1:0] next_upd, merges_upd;
  logic [CW-1:0]         count_c;
  logic [PW-1:0]         lab_ext;
  rcc_pkg::cell_ctrl_t   ctrl;

  assign in_acc  = in_pix.valid && in_pix.ready;
  assign cfg_acc = cfg_wr.valid && cfg_wr.ready;
  assign in_pix.ready = !out_valid_r || out_res.ready;
  assign cfg_wr.ready = 1'b1;

  // effective sizes: zero acts as one, oversize clamps
  always_comb begin
    w_ext = EW'(width_r);
    if (w_ext == '0) begin
      w_eff = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      w_eff = EW'(MAX_WIDTH);
    end else begin
      w_eff = w_ext;
    end
    w_m1  = XW'(w_eff - EW'(1));
    start = XW'(MAX_WIDTH - 1) - w_m1;

    h_dec = height_r - 9'd1;
    if (height_r == '0) begin
      h_m1 = '0;
    end else if (height_r > rcc_pkg::DIM_RESET) begin
      h_m1 = '1;
    end else begin
      h_m1 = h_dec[YW-1:0];
    end
  end

  always_comb begin
    left_c  = (x_r != '0) ? left_r : '0;
    up_c    = (y_r != '0) ? up_lab : '0;
    merge_c = 1'b0;
    fresh_c = 1'b0;
    lab_c   = '0;
    if (in_pix.pixel) begin
      if (left_c != '0) begin
        if (up_c != '0 && up_c != left_c) begin
          merge_c = 1'b1;
          lab_c   = up_c;
        end else begin
          lab_c = left_c;
        end
      end else if (up_c != '0) begin
        lab_c = up_c;
      end else begin
        fresh_c = 1'b1;
        lab_c   = next_r;
      end
    end
    next_upd   = (fresh_c && next_r != LabelMax) ? next_r + 1'b1 : next_r;
    merges_upd = merge_c ? merges_r + 1'b1 : merges_r;
    count_c    = CW'(next_upd) - CW'(1) - CW'(merges_upd);
    lab_ext    = PW'(lab_c);
    done_c     = (x_r == w_m1) && (y_r == h_m1);
  end

  assign ctrl.shift = in_acc;
  assign ctrl.merge = merge_c;

  rcc_row #(
    .MAX_WIDTH  (MAX_WIDTH),
    .LABEL_BITS (LABEL_BITS)
  ) u_row (
    .clk      (clk),
    .ctrl     (ctrl),
    .start    (start),
    .from_lab (left_c),
    .to_lab   (up_c),
    .new_lab  (lab_c),
    .up_lab   (up_lab)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= rcc_pkg::DIM_RESET;
      height_r    <= rcc_pkg::DIM_RESET;
      x_r         <= '0;
      y_r         <= '0;
      next_r      <= LABEL_BITS'(1);
      merges_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        if (cfg_wr.index == rcc_pkg::REG_IMAGE_WIDTH) begin
          width_r <= cfg_wr.data;
        end
        if (cfg_wr.index == rcc_pkg::REG_IMAGE_WIDTH ||
            cfg_wr.index == rcc_pkg::REG_IMAGE_HEIGHT) begin
          if (cfg_wr.index == rcc_pkg::REG_IMAGE_HEIGHT) begin
            height_r <= cfg_wr.data;
          end
          x_r      <= '0;
          y_r      <= '0;
          next_r   <= LABEL_BITS'(1);
          merges_r <= '0;
        end
      end else if (in_acc) begin
        if (done_c) begin
          x_r      <= '0;
          y_r      <= '0;
          next_r   <= LABEL_BITS'(1);
          merges_r <= '0;
        end else begin
          next_r   <= next_upd;
          merges_r <= merges_upd;
          if (x_r == w_m1) begin
            x_r <= '0;
            y_r <= y_r + 1'b1;
          end else begin
            x_r <= x_r + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r  <= lab_c;
      label_r <= lab_ext[rcc_pkg::OUT_BITS-1:0];
      count_r <= count_c[rcc_pkg::OUT_BITS-1:0];
      done_r  <= done_c;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.pixel_label = label_r;
  assign out_res.part_count  = count_r;
  assign out_res.frame_done  = done_r;

  a_col_in_row: assert property (@(posedge clk) disable iff (!rst_n)
    x_r <= w_m1)
    else $error("column position beyond row width");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !cfg_acc && done_c |=> x_r == '0 && y_r == '0 && next_r == LABEL_BITS'(1))
    else $error("frame did not restart after last pixel");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_pix.pixel |=> out_res.valid && out_res.pixel_label == '0)
    else $error("empty pixel got a label");

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

typedef struct packed {
  logic [15:0] label;
  logic [15:0] count;
  logic        done;
} pixel_word_t;

class label_predictor;
  bit [8:0]     width_reg;
  bit [8:0]     height_reg;
  logic [15:0]  row_store [256];
  bit [7:0]     col_pos;
  bit [7:0]     row_pos;
  bit [15:0]    next_label;
  bit [15:0]    merges;
  pixel_word_t  pending_words [$];
  int           mismatches;
  int           merges_seen;
  int           frames_done;

  function new();
    width_reg  = rcc_pkg::DIM_RESET;
    height_reg = rcc_pkg::DIM_RESET;
    foreach (row_store[i]) row_store[i] = '0;
    restart();
  endfunction

  function void restart();
    col_pos    = '0;
    row_pos    = '0;
    next_label = 16'd1;
    merges     = '0;
  endfunction

  function void write_reg(input logic [rcc_pkg::CFG_IDX_BITS-1:0] idx,
                          input logic [rcc_pkg::CFG_DATA_BITS-1:0] val);
    if (idx == rcc_pkg::REG_IMAGE_WIDTH) begin
      width_reg = val;
      restart();
    end else if (idx == rcc_pkg::REG_IMAGE_HEIGHT) begin
      height_reg = val;
      restart();
    end
  endfunction

  function void note_pixel(input bit px);
    int          w;
    int          h;
    int          x;
    int          y;
    int          i;
    logic [15:0] left;
    logic [15:0] up;
    logic [15:0] lab;
    pixel_word_t word;
    w = (width_reg == 0) ? 1 : (width_reg > 256) ? 256 : int'(width_reg);
    h = (height_reg == 0) ? 1 : (height_reg > 256) ? 256 : int'(height_reg);
    x = col_pos;
    y = row_pos;
    if (x >= w) x = 0;
    if (y >= h) y = 0;
    lab  = '0;
    left = '0;
    up   = '0;
    if (px) begin
      // outside the image counts as empty
      if (x > 0) left = row_store[x-1];
      if (y > 0) up = row_store[x];
      if (left != 0) begin
        if (up != 0 && up != left) begin
          for (i = 0; i < w; i++)
            if (row_store[i] == left) row_store[i] = up;
          merges++;
          merges_seen++;
          lab = up;
        end else begin
          lab = left;
        end
      end else if (up != 0) begin
        lab = up;
      end else begin
        lab = next_label;
        if (next_label != 16'hFFFF) next_label++;
      end
    end
    row_store[x] = lab;
    word.label = lab;
    word.count = next_label - 16'd1 - merges;
    word.done  = (x == w - 1) && (y == h - 1);
    pending_words.push_back(word);
    if (word.done) begin
      restart();
    end else begin
      x++;
      if (x >= w) begin
        x = 0;
        y++;
      end
      col_pos = x[7:0];
      row_pos = y[7:0];
    end
  endfunction

  function void check_word(input logic [15:0] label, input logic [15:0] count,
                           input logic done);
    pixel_word_t want;
    if (pending_words.size() == 0) begin
      $error("result word with nothing pending: pixel_label %0d part_count %0d frame_done %0b",
             label, count, done);
      mismatches++;
      return;
    end
    want = pending_words.pop_front();
    if (label !== want.label) begin
      $error("pixel_label: expected %0d, actual %0d", want.label, label);
      mismatches++;
    end
    if (count !== want.count) begin
      $error("part_count: expected %0d, actual %0d", want.count, count);
      mismatches++;
    end
    if (done !== want.done) begin
      $error("frame_done: expected %0b, actual %0b", want.done, done);
      mismatches++;
    end
    if (want.done) frames_done++;
  endfunction
endclass

module tb;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASES      = 8;

  bit   clk = 1'b0;
  logic rst_n;

  rcc_pix_if pix_ch ();
  rcc_res_if res_ch ();
  rcc_cfg_if cfg_ch ();

  raster_component_counter i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_res (res_ch),
    .cfg_wr  (cfg_ch)
  );

  label_predictor labeller;

  int cycle_count;
  int ready_hold;
  int pixels_sent;
  int settings_used;
  bit in_calm;
  bit out_calm;

  // width, height, pixels, fill percentage per phase; 0 and 511 probe clamping
  int ph_w    [PHASES] = '{4, 1, 0, 256, 1, 511, 7, 16};
  int ph_h    [PHASES] = '{3, 1, 0, 2, 256, 511, 5, 9};
  int ph_n    [PHASES] = '{150, 40, 30, 520, 260, 40, 150, 150};
  int ph_fill [PHASES] = '{60, 70, 50, 75, 80, 55, 85, 65};

  always #1 clk = ~clk;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_pixel(input bit px);
    int gap;
    if ($urandom_range(0, 99) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : pick_gap();
    if (gap > 0) begin
      pix_ch.valid <= 1'b0;
      pix_ch.pixel <= 1'($urandom);
      repeat (gap) @(posedge clk);
    end
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= px;
    @(posedge clk);
    while (!pix_ch.ready) @(posedge clk);
    labeller.note_pixel(px);
    pixels_sent++;
  endtask

  task automatic drain();
    while (labeller.pending_words.size() != 0) @(posedge clk);
  endtask

  // both writes back to back; valid stays high across them
  task automatic set_image_size(input int w, input int h);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= rcc_pkg::REG_IMAGE_WIDTH;
    cfg_ch.data  <= w[8:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    labeller.write_reg(rcc_pkg::REG_IMAGE_WIDTH, w[8:0]);
    cfg_ch.index <= rcc_pkg::REG_IMAGE_HEIGHT;
    cfg_ch.data  <= h[8:0];
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    labeller.write_reg(rcc_pkg::REG_IMAGE_HEIGHT, h[8:0]);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic run_phase(input int w, input int h, input int n, input int fill);
    int k;
    set_image_size(w, h);
    for (k = 0; k < n; k++) begin
      // hold off until the block has emptied, once mid-phase and now and then
      if (labeller.pending_words.size() != 0 &&
          (k == n / 2 || $urandom_range(0, 249) == 0)) begin
        pix_ch.valid <= 1'b0;
        drain();
      end
      send_pixel($urandom_range(0, 99) < fill);
    end
    pix_ch.valid <= 1'b0;
    drain();
  endtask

  always @(posedge clk) begin
    if ($urandom_range(0, 99) == 0) out_calm = !out_calm;
    if (ready_hold > 0) begin
      ready_hold--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
      if (!out_calm && $urandom_range(0, 3) == 0) ready_hold = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n && res_ch.valid && res_ch.ready)
      labeller.check_word(res_ch.pixel_label, res_ch.part_count, res_ch.frame_done);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    int p;
    pix_ch.valid = 1'b0;
    pix_ch.pixel = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data  = '0;
    rst_n        = 1'b0;
    labeller     = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset sizes: top row, fresh labels, left copy
    send_pixel(1'b1);
    send_pixel(1'b1);
    send_pixel(1'b0);
    send_pixel(1'b1);
    pix_ch.valid <= 1'b0;
    drain();

    // U shape on 4x3: the last pixel merges two parts and ends the frame
    set_image_size(4, 3);
    for (p = 11; p >= 0; p--) send_pixel(1'(12'b1011_1001_1111 >> p));
    // next frame starts clean, then a size write cuts it short
    send_pixel(1'b1);
    send_pixel(1'b1);
    pix_ch.valid <= 1'b0;
    drain();

    for (p = 0; p < PHASES; p++) run_phase(ph_w[p], ph_h[p], ph_n[p], ph_fill[p]);
    run_phase($urandom_range(2, 20), $urandom_range(2, 12), 100, $urandom_range(30, 85));

    repeat (10) @(posedge clk);
    $display("%0d pixels over %0d size settings, %0d frames completed, %0d merges",
             pixels_sent, settings_used, labeller.frames_done, labeller.merges_seen);
    if (labeller.mismatches == 0 && labeller.pending_words.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
